>>> src/tns_pkg.sv
// ----------------------------------------------------------------------------
// Tone note sequencer package
// Operation codes, field widths and parameter defaults for the sequencer.
// ----------------------------------------------------------------------------
package tns_pkg;

   // Parameter defaults.
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int FREQ_BITS_DEF   = 16;
   localparam int DUR_BITS_DEF    = 16;

   // Fixed field widths.
   localparam int OP_BITS   = 3;
   localparam int POS_BITS  = 6;
   localparam int LEN_BITS  = 7;

   // Longest sequence; longer play lengths saturate to this.
   localparam int LEN_MAX   = 64;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK        = 3'd0,
      OP_LOAD        = 3'd1,
      OP_PLAY        = 3'd2,
      OP_STOP        = 3'd3,
      OP_SET_MUTE    = 3'd4,
      OP_TOGGLE_MUTE = 3'd5
   } op_type;

endpackage

>>> src/tone_note_sequencer.sv
// ----------------------------------------------------------------------------
// Tone note sequencer
// Plays sequences of notes (frequency, duration in ms) from a note table.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the req_ channel (valid/stall); each carries one operation:
// tick (one millisecond), load note, play, stop, set mute or toggle mute.
// Every request yields exactly one response on the rsp_ channel with the
// tone, play status, position and mute state after that request.
// The note table lives in one RAM whose read port is always addressed by the
// note that will be current after the present request, so the entry is ready
// when the next request arrives; a load to that entry is forwarded.
// A request accepted into the second stage has its response registered in the
// output register. Throughput: one request per clock cycle while rsp_stall is
// low, set by the single read-modify pass over the current table entry.
// When the receiver stalls, one response waits in the output register and one
// more request is taken into the second stage; after that req_stall rises.
// Reset clears the player to idle and unmuted with no responses pending; the
// note table is not cleared and must be loaded before it is played.
// ----------------------------------------------------------------------------
module tone_note_sequencer
   import tns_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FREQ_BITS   = FREQ_BITS_DEF,
   parameter int DUR_BITS    = DUR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_BITS-1:0]   req_operation,
   input  logic [POS_BITS-1:0]  req_note_addr,
   input  logic [FREQ_BITS-1:0] req_note_freq,
   input  logic [DUR_BITS-1:0]  req_note_dur,
   input  logic [LEN_BITS-1:0]  req_seq_len,
   input  logic                 req_loop_enable,
   input  logic                 req_mute_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FREQ_BITS-1:0] rsp_tone_freq,
   output logic                 rsp_tone_on,
   output logic                 rsp_playing,
   output logic [POS_BITS-1:0]  rsp_position,
   output logic                 rsp_muted,
   output logic                 rsp_sequence_done
);

   localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int WORD_BITS = FREQ_BITS + DUR_BITS;
   localparam int SUM_RANGE = 1 << (POS_BITS + 1);
   localparam logic [DUR_BITS-1:0] DUR_MAX = {DUR_BITS{1'b1}};

   // Player state.
   logic [POS_BITS-1:0] seq_base_ff, seq_base_in;
   logic [LEN_BITS-1:0] seq_length_ff, seq_length_in;
   logic [POS_BITS-1:0] note_pos_ff, note_pos_in;
   logic [DUR_BITS-1:0] elapsed_ff, elapsed_in;
   logic                loop_ff, loop_in;
   logic                active_ff, active_in;
   logic                mute_ff, mute_in;
   logic                done_in;

   // Pipeline and output registers.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_done_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FREQ_BITS-1:0] rsp_tone_freq_ff;
   logic                 rsp_tone_on_ff;
   logic                 rsp_playing_ff;
   logic [POS_BITS-1:0]  rsp_position_ff;
   logic                 rsp_muted_ff;
   logic                 rsp_done_ff;

   // Table access.
   logic [ADDR_BITS-1:0] mod_lut [SUM_RANGE];
   logic                 wr_en;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [WORD_BITS-1:0] fwd_word_ff;
   logic [WORD_BITS-1:0] cur_word;
   logic [FREQ_BITS-1:0] cur_freq;
   logic [DUR_BITS-1:0]  cur_dur;
   logic [LEN_BITS-1:0]  sum_in;

   logic                 req_accept;
   logic                 s1_move;
   logic [DUR_BITS-1:0]  elapsed_sat;
   logic [LEN_BITS-1:0]  next_pos;
   logic [FREQ_BITS-1:0] tone_s1;

   // Table index modulo the table depth, as a constant lookup.
   for (genvar gi = 0; gi < SUM_RANGE; gi++) begin : g_mod
      assign mod_lut[gi] = ADDR_BITS'(gi % TABLE_DEPTH);
   end

   // Handshake.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   // Current note entry; a write to it at the last edge is forwarded.
   assign cur_word = fwd_hit_ff ? fwd_word_ff : ram_rd_data;
   assign cur_freq = cur_word[WORD_BITS-1:DUR_BITS];
   assign cur_dur  = cur_word[DUR_BITS-1:0];

   assign elapsed_sat = (elapsed_ff != DUR_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign next_pos    = {1'b0, note_pos_ff} + 1'b1;

   always_comb begin
      seq_base_in   = seq_base_ff;
      seq_length_in = seq_length_ff;
      note_pos_in   = note_pos_ff;
      elapsed_in    = elapsed_ff;
      loop_in       = loop_ff;
      active_in     = active_ff;
      mute_in       = mute_ff;
      done_in       = 1'b0;
      if (req_accept) begin
         case (op_type'(req_operation))
            OP_TICK: begin
               if (active_ff) begin
                  elapsed_in = elapsed_sat;
                  if (elapsed_sat >= cur_dur) begin
                     elapsed_in  = '0;
                     note_pos_in = next_pos[POS_BITS-1:0];
                     if (next_pos >= seq_length_ff) begin
                        note_pos_in = '0;
                        if (!loop_ff) begin
                           active_in     = 1'b0;
                           seq_length_in = '0;
                           done_in       = 1'b1;
                        end
                     end
                  end
               end
            end
            OP_PLAY: begin
               if (req_seq_len != '0) begin
                  seq_base_in   = req_note_addr;
                  seq_length_in = (req_seq_len > LEN_BITS'(LEN_MAX)) ?
                                  LEN_BITS'(LEN_MAX) : req_seq_len;
                  loop_in       = req_loop_enable;
                  note_pos_in   = '0;
                  elapsed_in    = '0;
                  active_in     = 1'b1;
               end
            end
            OP_STOP: begin
               active_in     = 1'b0;
               seq_length_in = '0;
               note_pos_in   = '0;
               elapsed_in    = '0;
            end
            OP_SET_MUTE: begin
               mute_in = req_mute_value;
            end
            OP_TOGGLE_MUTE: begin
               mute_in = !mute_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // The read port always follows the note that is current after this edge.
   assign sum_in     = {1'b0, seq_base_in} + {1'b0, note_pos_in};
   assign rd_addr    = reset ? '0 : mod_lut[sum_in];
   assign wr_en      = req_accept && (op_type'(req_operation) == OP_LOAD);
   assign wr_addr    = mod_lut[{1'b0, req_note_addr}];
   assign wr_data    = {req_note_freq, req_note_dur};
   assign fwd_hit_in = wr_en && (wr_addr == rd_addr);

   tns_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Second stage: the state now reflects the request held here.
   assign tone_s1      = (active_ff && !mute_ff) ? cur_freq : '0;
   assign s1_valid_in  = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_base_ff   <= '0;
         seq_length_ff <= '0;
         note_pos_ff   <= '0;
         elapsed_ff    <= '0;
         loop_ff       <= 1'b0;
         active_ff     <= 1'b0;
         mute_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         seq_base_ff   <= seq_base_in;
         seq_length_ff <= seq_length_in;
         note_pos_ff   <= note_pos_in;
         elapsed_ff    <= elapsed_in;
         loop_ff       <= loop_in;
         active_ff     <= active_in;
         mute_ff       <= mute_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_word_ff <= wr_data;
      if (req_accept) begin
         s1_done_ff <= done_in;
      end
      if (s1_move) begin
         rsp_tone_freq_ff <= tone_s1;
         rsp_tone_on_ff   <= (tone_s1 != '0);
         rsp_playing_ff   <= active_ff;
         rsp_position_ff  <= note_pos_ff;
         rsp_muted_ff     <= mute_ff;
         rsp_done_ff      <= s1_done_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tone_freq     = rsp_tone_freq_ff;
   assign rsp_tone_on       = rsp_tone_on_ff;
   assign rsp_playing       = rsp_playing_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_muted         = rsp_muted_ff;
   assign rsp_sequence_done = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_idle_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_playing |-> rsp_position == '0)
      else $error("idle response reports a nonzero position");

   a_tone_needs_play: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tone_on |-> rsp_playing && !rsp_muted)
      else $error("tone sounds while idle or muted");

   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sequence_done |-> !rsp_playing)
      else $error("sequence end reported while still playing");

   a_active_len: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> seq_length_ff != '0 && seq_length_ff <= LEN_BITS'(LEN_MAX))
      else $error("active sequence with an invalid length");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request lost before the second stage");
`endif

endmodule

>>> src/tns_ram.sv
// ----------------------------------------------------------------------------
// Tone note sequencer RAM
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read at the address being written returns old data.
// ----------------------------------------------------------------------------
module tns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
